// File: hw/rtl/jsu_pkg.sv
package jsu_pkg;

	// Decoder phase codes; the codes above the trail digits are never entered.
	typedef enum logic [3:0] {
		PH_IDLE = 4'd0,
		PH_TEXT = 4'd1,
		PH_ESC  = 4'd2,
		PH_HEX1 = 4'd3,
		PH_HEX2 = 4'd4,
		PH_HEX3 = 4'd5,
		PH_HEX4 = 4'd6,
		PH_MK1  = 4'd7,
		PH_MK2  = 4'd8,
		PH_TR1  = 4'd9,
		PH_TR2  = 4'd10,
		PH_TR3  = 4'd11,
		PH_TR4  = 4'd12
	} phase_t;

	// Status carried with every result.
	typedef enum logic [1:0] {
		ST_DATA       = 2'd0,
		ST_DONE       = 2'd1,
		ST_INVALID    = 2'd2,
		ST_INCOMPLETE = 2'd3
	} status_t;

	localparam int unsigned MaxResults = 4;
	localparam int unsigned CountW     = 3;
	localparam int unsigned CodeW      = 21;

	// All results caused by one input byte. A status result is always alone
	// and carries a zero byte; data results go out from entry 0 upwards.
	typedef struct packed {
		logic [CountW-1:0]            count;
		status_t                      status;
		logic [MaxResults-1:0][7:0]   data;
	} bundle_t;

	// UTF-8 encoding of one code point into one to four bytes.
	function automatic bundle_t utf8_encode(input logic [CodeW-1:0] cp);
		bundle_t b;
		b = '0;
		b.status = ST_DATA;
		if (cp <= 21'h00007f) begin
			b.count   = 3'd1;
			b.data[0] = cp[7:0];
		end else if (cp <= 21'h0007ff) begin
			b.count   = 3'd2;
			b.data[0] = {3'b110, cp[10:6]};
			b.data[1] = {2'b10, cp[5:0]};
		end else if (cp <= 21'h00ffff) begin
			b.count   = 3'd3;
			b.data[0] = {4'b1110, cp[15:12]};
			b.data[1] = {2'b10, cp[11:6]};
			b.data[2] = {2'b10, cp[5:0]};
		end else begin
			b.count   = 3'd4;
			b.data[0] = {5'b11110, cp[20:18]};
			b.data[1] = {2'b10, cp[17:12]};
			b.data[2] = {2'b10, cp[11:6]};
			b.data[3] = {2'b10, cp[5:0]};
		end
		return b;
	endfunction

endpackage

// File: hw/rtl/jsu_if.sv
// Input channel: one raw string byte or an end-of-input command per request.
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] in_byte;

	modport source (output valid, output command, output in_byte, input ready);
	modport sink   (input valid, input command, input in_byte, output ready);
endinterface

// Output channel: one decoded byte or one status result per request.
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output out_byte, output status, output last, input ready);
	modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// File: hw/rtl/jsu_decoder.sv
module jsu_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              command,
	input  logic [7:0]        in_byte,
	output jsu_pkg::bundle_t  bundle
);
	import jsu_pkg::*;

	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChBslash = 8'h5c;
	localparam logic [7:0] ChSlash  = 8'h2f;
	localparam logic [7:0] ChU      = 8'h75;

	phase_t      phase_q, phase_d;
	logic [15:0] hex_q, hex_d;
	logic [9:0]  lead_q, lead_d;
	logic        digit_bad_q, digit_bad_d;
	logic        marker_bad_q, marker_bad_d;
	logic        skip_q, skip_d;
	logic        held_q, held_d;

	logic [3:0]  nib;
	logic        nib_bad;
	logic [15:0] hex_new;
	logic        bad_new;
	logic        in_string;
	logic [CodeW-1:0] pair_cp;

	// Hex digit value of the current byte; a non-hex byte counts as zero.
	always_comb begin
		nib     = 4'd0;
		nib_bad = 1'b0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			nib = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			nib = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			nib = 4'(in_byte - 8'h37);
		end else begin
			nib_bad = 1'b1;
		end
	end

	assign hex_new   = {hex_q[11:0], nib};
	assign bad_new   = digit_bad_q | nib_bad;
	assign in_string = (phase_q >= PH_TEXT) && (phase_q <= PH_TR4);
	// The trail's low ten bits are its offset from the trail base.
	assign pair_cp   = CodeW'(21'h010000 + {1'b0, lead_q, hex_new[9:0]});

	// Next state and the results of the byte in the input stage.
	always_comb begin
		phase_d      = phase_q;
		hex_d        = hex_q;
		lead_d       = lead_q;
		digit_bad_d  = digit_bad_q;
		marker_bad_d = marker_bad_q;
		skip_d       = skip_q;
		held_d       = held_q;
		bundle       = '0;
		bundle.status = ST_DATA;

		if (command) begin
			bundle.count  = 3'd1;
			bundle.status = ST_INCOMPLETE;
			phase_d = PH_IDLE; hex_d = '0; lead_d = '0;
			digit_bad_d = 1'b0; marker_bad_d = 1'b0; skip_d = 1'b0; held_d = 1'b0;
		end else if (!in_string) begin
			phase_d = (in_byte == ChQuote) ? PH_TEXT : PH_IDLE;
			hex_d = '0; lead_d = '0;
			digit_bad_d = 1'b0; marker_bad_d = 1'b0; skip_d = 1'b0; held_d = 1'b0;
			if (in_byte != ChQuote) begin
				bundle.count  = 3'd1;
				bundle.status = ST_INVALID;
			end
		end else if (in_byte == ChQuote && !skip_q) begin
			bundle.count = 3'd1;
			if (held_q) begin
				bundle.status = ST_INVALID;
			end else if (phase_q == PH_TEXT) begin
				bundle.status = ST_DONE;
			end else begin
				bundle.status = ST_INCOMPLETE;
			end
			phase_d = PH_IDLE; hex_d = '0; lead_d = '0;
			digit_bad_d = 1'b0; marker_bad_d = 1'b0; skip_d = 1'b0; held_d = 1'b0;
		end else begin
			skip_d = !skip_q && (in_byte == ChBslash);
			if (!held_q) begin
				unique case (phase_q)
					PH_TEXT: begin
						if (in_byte == ChBslash) begin
							phase_d = PH_ESC;
						end else begin
							bundle.count   = 3'd1;
							bundle.data[0] = in_byte;
						end
					end
					PH_ESC: begin
						phase_d = PH_TEXT;
						unique case (in_byte)
							ChQuote, ChBslash, ChSlash: begin
								bundle.count   = 3'd1;
								bundle.data[0] = in_byte;
							end
							8'h6e: begin
								bundle.count   = 3'd1;
								bundle.data[0] = 8'h0a;
							end
							8'h72: begin
								bundle.count   = 3'd1;
								bundle.data[0] = 8'h0d;
							end
							8'h74: begin
								bundle.count   = 3'd1;
								bundle.data[0] = 8'h09;
							end
							8'h62: begin
								bundle.count   = 3'd1;
								bundle.data[0] = 8'h08;
							end
							8'h66: begin
								bundle.count   = 3'd1;
								bundle.data[0] = 8'h0c;
							end
							ChU: begin
								hex_d       = '0;
								digit_bad_d = 1'b0;
								phase_d     = PH_HEX1;
							end
							default: begin
								held_d = 1'b1;
							end
						endcase
					end
					PH_HEX1, PH_HEX2, PH_HEX3, PH_TR1, PH_TR2, PH_TR3: begin
						hex_d       = hex_new;
						digit_bad_d = bad_new;
						phase_d     = phase_t'(phase_q + 4'd1);
					end
					PH_HEX4: begin
						hex_d       = hex_new;
						digit_bad_d = bad_new;
						phase_d     = PH_TEXT;
						if (bad_new || (hex_new >= 16'hdc00 && hex_new <= 16'hdfff)) begin
							held_d = 1'b1;
						end else if (hex_new >= 16'hd800 && hex_new <= 16'hdbff) begin
							lead_d       = hex_new[9:0];
							marker_bad_d = 1'b0;
							phase_d      = PH_MK1;
						end else begin
							bundle = utf8_encode({5'd0, hex_new});
						end
					end
					PH_MK1: begin
						if (in_byte != ChBslash) begin
							marker_bad_d = 1'b1;
						end
						phase_d = PH_MK2;
					end
					PH_MK2: begin
						if (in_byte != ChU) begin
							marker_bad_d = 1'b1;
						end
						hex_d       = '0;
						digit_bad_d = 1'b0;
						phase_d     = PH_TR1;
					end
					PH_TR4: begin
						hex_d       = hex_new;
						digit_bad_d = bad_new;
						phase_d     = PH_TEXT;
						if (marker_bad_q || bad_new || hex_new < 16'hdc00
								|| hex_new > 16'hdfff) begin
							held_d = 1'b1;
						end else begin
							bundle = utf8_encode(pair_cp);
						end
					end
					default: begin
						phase_d = phase_q;
					end
				endcase
			end
		end
	end

	// Decoder state, updated whenever the input stage hands on its byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			hex_q        <= '0;
			lead_q       <= '0;
			digit_bad_q  <= 1'b0;
			marker_bad_q <= 1'b0;
			skip_q       <= 1'b0;
			held_q       <= 1'b0;
		end else if (advance) begin
			phase_q      <= phase_d;
			hex_q        <= hex_d;
			lead_q       <= lead_d;
			digit_bad_q  <= digit_bad_d;
			marker_bad_q <= marker_bad_d;
			skip_q       <= skip_d;
			held_q       <= held_d;
		end
	end

endmodule

// File: hw/rtl/jsu_serializer.sv
module jsu_serializer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  jsu_pkg::bundle_t  bundle,
	output logic              can_load,
	jsu_out_if.source         decoded
);
	import jsu_pkg::*;

	bundle_t    bundle_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       is_last;
	logic       done_now;

	assign is_last  = ({1'b0, idx_q} == (bundle_q.count - 3'd1));
	assign done_now = busy_q && decoded.ready && is_last;
	assign can_load = !busy_q || done_now;

	// Present the current result of the held bundle.
	assign decoded.valid    = busy_q;
	assign decoded.out_byte = bundle_q.data[idx_q];
	assign decoded.status   = bundle_q.status;
	assign decoded.last     = is_last;

	// Control: a new bundle replaces the old one as its final result is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (can_load) begin
			busy_q <= load && (bundle.count != '0);
			idx_q  <= '0;
		end else if (decoded.ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// Payload of the held bundle.
	always_ff @(posedge clk) begin
		if (can_load && load) begin
			bundle_q <= bundle;
		end
	end

endmodule

// File: hw/rtl/json_string_unescape_to_utf8.sv
// JSON string unescaper with UTF-8 output.
// The text channel takes one request per byte of a quoted JSON string, the
// opening and closing quotes included; command set marks end of input.
// The decoded channel returns the unescaped string as UTF-8 bytes (status
// 0), then one status result for the string: done, invalid or incomplete.
// A request gives zero to four results, and last marks the final one.
// A request is registered in the input stage, then decoded into a result
// register, from which its first result is presented.
// One request enters every cycle while each gives at most one result and
// the receiver is ready; a request giving n results holds the result
// register until its final result is taken, as the decoded channel moves
// one result per cycle while the receiver is ready.
// When the receiver stalls, the result register and then the input stage
// fill, and text.ready falls until the final held result is taken.
// Reset clears all decoder state: the block waits for an opening quote,
// and nothing is held in either stage.
module json_string_unescape_to_utf8 (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    text,
	jsu_out_if.source decoded
);
	import jsu_pkg::*;

	logic       valid_s1;
	logic       command_s1;
	logic [7:0] byte_s1;
	logic       can_load;
	logic       advance;
	bundle_t    bundle;

	assign advance    = valid_s1 && can_load;
	assign text.ready = !valid_s1 || advance;

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (text.ready && text.valid) begin
			command_s1 <= text.command;
			byte_s1    <= text.in_byte;
		end
	end

	jsu_decoder u_decoder (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.command (command_s1),
		.in_byte (byte_s1),
		.bundle  (bundle)
	);

	jsu_serializer u_serializer (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.bundle   (bundle),
		.can_load (can_load),
		.decoded  (decoded)
	);

endmodule
